// ===== design/pis_pkg.sv =====
// ============================================================================
// pis_pkg: shared types and constants of the PID integral separation block
// Field widths, register map, reset values and datapath widths.
// ============================================================================
package pis_pkg;

    // Input and output field widths
    localparam int ANGLE_W = 24;                // setpoint, measurement (Q16.8)
    localparam int DRIVE_W = 32;                // drive (Q24.8)

    // Configuration register widths
    localparam int GAIN_W  = 24;                // kp, ki, kd (unsigned Q10.14)
    localparam int LIMIT_W = 23;                // window and integral limit (unsigned Q15.8)

    // Datapath widths
    localparam int ERR_W   = ANGLE_W + 1;       // setpoint - measurement
    localparam int INT_W   = 24;                // integral state
    localparam int ACC_W   = ERR_W + 1;         // integral plus error, before clamp
    localparam int DIFF_W  = ERR_W + 1;         // error - previous error
    localparam int P_KP_W  = GAIN_W + 1 + ERR_W;
    localparam int P_KI_W  = GAIN_W + 1 + INT_W;
    localparam int P_KD_W  = GAIN_W + 1 + DIFF_W;
    localparam int SUM_W   = P_KD_W + 1;
    localparam int FRAC_W  = 14;                // gain fraction bits dropped at output
    localparam int SHR_W   = SUM_W - FRAC_W;    // rounded sum before saturation

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_W - 1);

    // APB register map
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    typedef enum logic [2:0] {
        REG_KP     = 3'd0,
        REG_KI     = 3'd1,
        REG_KD     = 3'd2,
        REG_WINDOW = 3'd3,
        REG_LIMIT  = 3'd4
    } t_reg_idx;

    localparam logic [GAIN_W-1:0]  KP_RST     = 24'd147456;   // 9.0
    localparam logic [GAIN_W-1:0]  KI_RST     = 24'd492;      // about 0.03
    localparam logic [GAIN_W-1:0]  KD_RST     = 24'd5734400;  // 350.0
    localparam logic [LIMIT_W-1:0] WINDOW_RST = 23'd5120;     // 20.0
    localparam logic [LIMIT_W-1:0] LIMIT_RST  = 23'd384000;   // 1500.0

    typedef struct packed {
        logic [GAIN_W-1:0]  kp;
        logic [GAIN_W-1:0]  ki;
        logic [GAIN_W-1:0]  kd;
        logic [LIMIT_W-1:0] window;
        logic [LIMIT_W-1:0] limit;
    } t_cfg;

endpackage

// ===== design/pis_in_if.sv =====
// ============================================================================
// pis_in_if: sample channel
// Valid/ready channel carrying one controller sample.
// ============================================================================
interface pis_in_if
    import pis_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] setpoint;
    logic signed [ANGLE_W-1:0] measurement;
    logic                      integrate_hold;

    modport source (output valid, output setpoint, output measurement,
                    output integrate_hold, input ready);
    modport sink   (input valid, input setpoint, input measurement,
                    input integrate_hold, output ready);
endinterface

// ===== design/pis_out_if.sv =====
// ============================================================================
// pis_out_if: drive channel
// Valid/ready channel carrying one controller output.
// ============================================================================
interface pis_out_if
    import pis_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

// ===== design/pis_apb_regs.sv =====
// ============================================================================
// pis_apb_regs: configuration registers
// APB write/read of gains, integration window and integral limit.
// ============================================================================
module pis_apb_regs
    import pis_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);
    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp     <= KP_RST;
            r_cfg.ki     <= KI_RST;
            r_cfg.kd     <= KD_RST;
            r_cfg.window <= WINDOW_RST;
            r_cfg.limit  <= LIMIT_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_KP:     r_cfg.kp     <= pwdata[GAIN_W-1:0];
                REG_KI:     r_cfg.ki     <= pwdata[GAIN_W-1:0];
                REG_KD:     r_cfg.kd     <= pwdata[GAIN_W-1:0];
                REG_WINDOW: r_cfg.window <= pwdata[LIMIT_W-1:0];
                REG_LIMIT:  r_cfg.limit  <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_KP:     prdata = PDATA_W'(r_cfg.kp);
            REG_KI:     prdata = PDATA_W'(r_cfg.ki);
            REG_KD:     prdata = PDATA_W'(r_cfg.kd);
            REG_WINDOW: prdata = PDATA_W'(r_cfg.window);
            REG_LIMIT:  prdata = PDATA_W'(r_cfg.limit);
            default:    prdata = '0;
        endcase
    end
endmodule

// ===== design/pis_err_stage.sv =====
// ============================================================================
// pis_err_stage: error, integral and derivative difference
// Forms the error, updates the clamped integral and the previous error.
// ============================================================================
module pis_err_stage
    import pis_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  logic signed [ANGLE_W-1:0] i_setpoint,
    input  logic signed [ANGLE_W-1:0] i_measurement,
    input  logic                      i_hold,
    input  t_cfg                      i_cfg,
    output logic signed [ERR_W-1:0]   o_err,
    output logic signed [INT_W-1:0]   o_integral,
    output logic signed [DIFF_W-1:0]  o_diff
);
    logic signed [INT_W-1:0]  r_integral;
    logic signed [ERR_W-1:0]  r_prev_err;
    logic signed [ERR_W-1:0]  r_err;
    logic signed [DIFF_W-1:0] r_diff;

    logic signed [ERR_W-1:0]  w_err;
    logic        [ERR_W-1:0]  w_mag;
    logic                     w_integrate;
    logic signed [ACC_W-1:0]  w_acc;
    logic signed [ACC_W-1:0]  w_lim;
    logic signed [INT_W-1:0]  n_integral;

    assign w_err = ERR_W'(i_setpoint) - ERR_W'(i_measurement);
    assign w_mag = w_err[ERR_W-1] ? ERR_W'(-w_err) : ERR_W'(w_err);
    assign w_integrate = !i_hold && (w_mag < ERR_W'(i_cfg.window));
    assign w_acc = ACC_W'(r_integral) + (w_integrate ? ACC_W'(w_err) : ACC_W'(0));
    assign w_lim = $signed(ACC_W'(i_cfg.limit));

    // Clamp to the symmetric limit on every item
    always_comb begin
        if (w_acc > w_lim) begin
            n_integral = INT_W'(w_lim);
        end else if (w_acc < -w_lim) begin
            n_integral = INT_W'(-w_lim);
        end else begin
            n_integral = INT_W'(w_acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral <= '0;
            r_prev_err <= '0;
        end else if (i_load) begin
            r_integral <= n_integral;
            r_prev_err <= w_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_err  <= w_err;
            r_diff <= DIFF_W'(w_err) - DIFF_W'(r_prev_err);
        end
    end

    assign o_err      = r_err;
    assign o_integral = r_integral;
    assign o_diff     = r_diff;
endmodule

// ===== design/pis_mac_stage.sv =====
// ============================================================================
// pis_mac_stage: gain products and sum
// Registers the three gain products, then their sum plus the rounding half.
// ============================================================================
module pis_mac_stage
    import pis_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_load_prod,
    input  logic                     i_load_sum,
    input  t_cfg                     i_cfg,
    input  logic signed [ERR_W-1:0]  i_err,
    input  logic signed [INT_W-1:0]  i_integral,
    input  logic signed [DIFF_W-1:0] i_diff,
    output logic signed [SUM_W-1:0]  o_sum
);
    logic signed [P_KP_W-1:0] r_p_kp;
    logic signed [P_KI_W-1:0] r_p_ki;
    logic signed [P_KD_W-1:0] r_p_kd;
    logic signed [SUM_W-1:0]  r_sum;

    logic signed [P_KP_W-1:0] w_p_kp;
    logic signed [P_KI_W-1:0] w_p_ki;
    logic signed [P_KD_W-1:0] w_p_kd;

    assign w_p_kp = $signed({1'b0, i_cfg.kp}) * i_err;
    assign w_p_ki = $signed({1'b0, i_cfg.ki}) * i_integral;
    assign w_p_kd = $signed({1'b0, i_cfg.kd}) * i_diff;

    always_ff @(posedge i_clk) begin
        if (i_load_prod) begin
            r_p_kp <= w_p_kp;
            r_p_ki <= w_p_ki;
            r_p_kd <= w_p_kd;
        end
        if (i_load_sum) begin
            r_sum <= SUM_W'(r_p_kp) + SUM_W'(r_p_ki) + SUM_W'(r_p_kd) + ROUND_HALF;
        end
    end

    assign o_sum = r_sum;
endmodule

// ===== design/pis_out_stage.sv =====
// ============================================================================
// pis_out_stage: scale and saturate
// Drops the gain fraction and saturates the drive to 32 bits.
// ============================================================================
module pis_out_stage
    import pis_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_load,
    input  logic signed [SUM_W-1:0]   i_sum,
    output logic signed [DRIVE_W-1:0] o_drive
);
    logic signed [DRIVE_W-1:0] r_drive;
    logic signed [SHR_W-1:0]   w_shr;
    logic                      w_fits;
    logic signed [DRIVE_W-1:0] n_drive;

    // Arithmetic shift gives the floor of the half-biased sum
    assign w_shr  = i_sum[SUM_W-1:FRAC_W];
    assign w_fits = (w_shr[SHR_W-1:DRIVE_W-1] == '0) || (w_shr[SHR_W-1:DRIVE_W-1] == '1);

    always_comb begin
        if (w_fits) begin
            n_drive = w_shr[DRIVE_W-1:0];
        end else if (w_shr[SHR_W-1]) begin
            n_drive = {1'b1, {(DRIVE_W-1){1'b0}}};
        end else begin
            n_drive = {1'b0, {(DRIVE_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_drive <= n_drive;
        end
    end

    assign o_drive = r_drive;
endmodule

// ===== design/pid_integral_separation.sv =====
// ============================================================================
// pid_integral_separation: positional PID with integral separation and clamp
// One sample in, one saturated drive value out, five-stage elastic pipeline.
// ============================================================================
// Each sample item gives one drive item. The pipeline has five registered
// stages (input, error/integral, gain products, sum, saturated output), and
// the block takes a new sample every cycle when nothing stalls. The integral
// update (add the error when allowed, then clamp) is combinational in the
// error/integral stage and is the loop that sets this one-item-per-cycle
// rate. Every stage has its own valid bit and fills as soon as its successor
// moves, so samples keep entering while a finished drive item waits at the
// output, until the stages behind it are full. The integral and the previous
// error advance when an item leaves the input register; reset clears both.
// Configuration registers sit behind the APB port at byte addresses 0 (kp),
// 4 (ki), 8 (kd), 12 (integration window) and 16 (integral limit); other
// word addresses read as zero and ignore writes.
module pid_integral_separation
    import pis_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    pis_in_if.sink             i_in,
    pis_out_if.source          o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);
    t_cfg w_cfg;

    // Stage valid bits
    logic r_vld_in, r_vld_err, r_vld_prod, r_vld_sum, r_vld_out;

    // Input register payload
    logic signed [ANGLE_W-1:0] r_setpoint;
    logic signed [ANGLE_W-1:0] r_measurement;
    logic                      r_hold;

    logic w_accept, w_deliver;
    logic w_load_err, w_load_prod, w_load_sum, w_load_out;
    logic w_rdy_in, w_rdy_err, w_rdy_prod, w_rdy_sum, w_rdy_out;

    logic signed [ERR_W-1:0]  w_err;
    logic signed [INT_W-1:0]  w_integral;
    logic signed [DIFF_W-1:0] w_diff;
    logic signed [SUM_W-1:0]  w_sum;

    pis_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Ready ripples back from the output: a stage takes an item when it is
    // empty or its own item moves on in the same cycle.
    always_comb begin
        w_rdy_out   = !r_vld_out || o_out.ready;
        w_load_out  = r_vld_sum && w_rdy_out;
        w_rdy_sum   = !r_vld_sum || w_load_out;
        w_load_sum  = r_vld_prod && w_rdy_sum;
        w_rdy_prod  = !r_vld_prod || w_load_sum;
        w_load_prod = r_vld_err && w_rdy_prod;
        w_rdy_err   = !r_vld_err || w_load_prod;
        w_load_err  = r_vld_in && w_rdy_err;
        w_rdy_in    = !r_vld_in || w_load_err;
    end

    assign i_in.ready = w_rdy_in;
    assign w_accept   = i_in.valid && w_rdy_in;
    assign w_deliver  = r_vld_out && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_in   <= 1'b0;
            r_vld_err  <= 1'b0;
            r_vld_prod <= 1'b0;
            r_vld_sum  <= 1'b0;
            r_vld_out  <= 1'b0;
        end else begin
            r_vld_in   <= w_accept    || (r_vld_in   && !w_load_err);
            r_vld_err  <= w_load_err  || (r_vld_err  && !w_load_prod);
            r_vld_prod <= w_load_prod || (r_vld_prod && !w_load_sum);
            r_vld_sum  <= w_load_sum  || (r_vld_sum  && !w_load_out);
            r_vld_out  <= w_load_out  || (r_vld_out  && !o_out.ready);
        end
    end

    // Capture the sample
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_setpoint    <= i_in.setpoint;
            r_measurement <= i_in.measurement;
            r_hold        <= i_in.integrate_hold;
        end
    end

    pis_err_stage u_err (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_load_err),
        .i_setpoint    (r_setpoint),
        .i_measurement (r_measurement),
        .i_hold        (r_hold),
        .i_cfg         (w_cfg),
        .o_err         (w_err),
        .o_integral    (w_integral),
        .o_diff        (w_diff)
    );

    pis_mac_stage u_mac (
        .i_clk       (i_clk),
        .i_load_prod (w_load_prod),
        .i_load_sum  (w_load_sum),
        .i_cfg       (w_cfg),
        .i_err       (w_err),
        .i_integral  (w_integral),
        .i_diff      (w_diff),
        .o_sum       (w_sum)
    );

    pis_out_stage u_out (
        .i_clk   (i_clk),
        .i_load  (w_load_out),
        .i_sum   (w_sum),
        .o_drive (o_out.drive)
    );

    assign o_out.valid = r_vld_out;

    // A taken sample always lands in the input register
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_vld_in)
        else $error("accepted item did not reach the input register");

    // Items in flight change only by accepts and deliveries
    a_item_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
            ($countones({r_vld_in, r_vld_err, r_vld_prod, r_vld_sum, r_vld_out})
             + int'($past(w_deliver)))
            == ($past($countones({r_vld_in, r_vld_err, r_vld_prod, r_vld_sum,
                                  r_vld_out})) + int'($past(w_accept))))
        else $error("pipeline lost or duplicated an item");

    // The updated integral stays inside the limit it was clamped against
    a_integral_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_err |=>
            (ACC_W'(w_integral) <= $signed(ACC_W'($past(w_cfg.limit)))) &&
            (ACC_W'(w_integral) >= -$signed(ACC_W'($past(w_cfg.limit)))))
        else $error("integral outside its clamp limit");
endmodule
